FILE: hw/rtl/sact_pkg.sv
`default_nettype none
package sact_pkg;
  localparam int unsigned NumSetsDefault    = 16384;
  localparam int unsigned NumWaysDefault    = 4;
  localparam int unsigned BlockBytesDefault = 64;

  localparam logic [1:0] OpRead  = 2'd0;
  localparam logic [1:0] OpWrite = 2'd1;
  localparam logic [1:0] OpInval = 2'd2;
  localparam logic [1:0] OpClear = 2'd3;

  localparam int unsigned AgeW = 8;
  localparam logic [AgeW-1:0] AgeMax = '1;
endpackage
`default_nettype wire

FILE: hw/rtl/sact_ram.sv
`default_nettype none
module sact_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: hw/rtl/sact_way_unit.sv
`default_nettype none
// Shared per-way unit: compare one stored way against the lookup tag and
// track hit, first invalid way and oldest way across the ways of a set.
module sact_way_unit
  import sact_pkg::*;
#(
  parameter int unsigned TagW = 12,
  parameter int unsigned WayW = 2
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            first_i,
  input  wire logic            step_i,
  input  wire logic [WayW-1:0] way_i,
  input  wire logic            valid_i,
  input  wire logic [TagW-1:0] tag_i,
  input  wire logic [AgeW-1:0] age_i,
  input  wire logic [TagW-1:0] look_tag_i,
  output logic                 hit_o,
  output logic [WayW-1:0]      hit_way_o,
  output logic                 inv_o,
  output logic [WayW-1:0]      inv_way_o,
  output logic [WayW-1:0]      old_way_o
);
  logic            hit_q, inv_q;
  logic [WayW-1:0] hit_way_q, inv_way_q, old_way_q;
  logic [AgeW-1:0] old_age_q;
  logic            match;

  assign match = valid_i && (tag_i == look_tag_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
      inv_q <= 1'b0;
    end else if (step_i) begin
      if (match && (first_i || !hit_q)) begin
        hit_q     <= 1'b1;
        hit_way_q <= way_i;
      end else if (first_i) begin
        hit_q <= 1'b0;
      end
      if (!valid_i && (first_i || !inv_q)) begin
        inv_q     <= 1'b1;
        inv_way_q <= way_i;
      end else if (first_i) begin
        inv_q <= 1'b0;
      end
      if (first_i || age_i > old_age_q) begin
        old_age_q <= age_i;
        old_way_q <= way_i;
      end
    end
  end

  assign hit_o     = hit_q;
  assign hit_way_o = hit_way_q;
  assign inv_o     = inv_q;
  assign inv_way_o = inv_way_q;
  assign old_way_o = old_way_q;
endmodule
`default_nettype wire

FILE: hw/rtl/set_assoc_cache_tag_controller.sv
`default_nettype none
// Channel     | Direction | Ports                                  | Handshake
// command     | in        | op_i, address_i                        | start_i && !busy_o
// result      | out       | hit_o, writeback_o, evicted_address_o, | done_o, one cycle
//             |           | line_found_o, *_count_o                |
// config      | in        | write_through_i                        | cfg_we_i
//
// A read or write goes from accept through one pass that reads a way per cycle
// from the line memory, a decision state, a second pass that writes back every
// way with its new age/state, and a finishing state.
// Invalidate uses the same read pass, a decision, an update state (a write only
// on a match) and the finishing state.
// After reset and after every clear a wipe walks all NUM_SETS*NUM_WAYS lines,
// one per cycle; busy_o stays high during it. The result cannot be stalled.
module set_assoc_cache_tag_controller
  import sact_pkg::*;
#(
  parameter int unsigned NUM_SETS    = NumSetsDefault,
  parameter int unsigned NUM_WAYS    = NumWaysDefault,
  parameter int unsigned BLOCK_BYTES = BlockBytesDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [31:0] address_i,
  input  wire logic        cfg_we_i,
  input  wire logic        write_through_i,
  output logic             done_o,
  output logic             hit_o,
  output logic             writeback_o,
  output logic [31:0]      evicted_address_o,
  output logic             line_found_o,
  output logic [31:0]      read_count_o,
  output logic [31:0]      write_count_o,
  output logic [31:0]      hit_count_o,
  output logic [31:0]      miss_count_o
);
  localparam int unsigned OffW  = $clog2(BLOCK_BYTES);
  localparam int unsigned SetW  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned SetB  = $clog2(NUM_SETS);
  localparam int unsigned TagW  = 32 - OffW - SetB;
  localparam int unsigned WayW  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int unsigned Lines = NUM_SETS * NUM_WAYS;
  localparam int unsigned LineW = (Lines > 1) ? $clog2(Lines) : 1;
  localparam int unsigned EntW  = 2 + TagW + AgeW;
  localparam logic [WayW-1:0] LastWay = WayW'(NUM_WAYS - 1);
  localparam logic [LineW-1:0] LastLine = LineW'(Lines - 1);

  localparam logic [2:0] StWipe = 3'd0;
  localparam logic [2:0] StIdle = 3'd1;
  localparam logic [2:0] StRead = 3'd2;
  localparam logic [2:0] StDec  = 3'd3;
  localparam logic [2:0] StUpd  = 3'd4;
  localparam logic [2:0] StDone = 3'd5;

  logic [2:0]       st_q, st_d;
  logic [LineW-1:0] wipe_q;
  logic [WayW-1:0]  cnt_q;      // way being read or written
  logic             rv_q;       // memory read data valid for way rway_q
  logic [WayW-1:0]  rway_q;
  logic [1:0]       op_q;
  logic [31:0]      addr_q;
  logic             wt_q;
  logic [31:0]      rd_q, wr_q, ht_q, ms_q;
  logic             hit_q, wb_q, found_q, done_q;
  logic [31:0]      ev_q;
  logic [WayW-1:0]  sel_q;      // accessed way (hit or victim), invalidated way
  logic             sel_ok_q;   // invalidate found a line, or a clear is pending

  logic [TagW-1:0] tag;
  logic [SetW-1:0] set_idx;
  logic [SetW-1:0] in_set;      // set of the command being presented

  if (SetB > 0) begin : g_set
    assign set_idx = addr_q[OffW +: SetB];
    assign in_set  = address_i[OffW +: SetB];
  end else begin : g_noset
    assign set_idx = 1'b0;
    assign in_set  = 1'b0;
  end
  assign tag = addr_q[31 -: TagW];

  // Line memory: {valid, dirty, tag, age}
  logic             we;
  logic [LineW-1:0] waddr, raddr;
  logic [EntW-1:0]  wdata, rdata;
  logic [EntW-1:0]  way_keep_q [NUM_WAYS]; // staging of set contents

  function automatic logic [LineW-1:0] line_of(logic [SetW-1:0] s, logic [WayW-1:0] w);
    logic [31:0] l;
    l = 32'(s) * 32'(NUM_WAYS) + 32'(w);
    return l[LineW-1:0];
  endfunction

  sact_ram #(.Width(EntW), .Depth(Lines)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  logic            m_valid;
  logic [TagW-1:0] m_tag;
  logic [AgeW-1:0] m_age;
  assign m_valid = rdata[EntW-1];
  assign m_tag   = rdata[AgeW +: TagW];
  assign m_age   = rdata[AgeW-1:0];

  logic            u_hit, u_inv;
  logic [WayW-1:0] hit_way, inv_way, old_way;

  sact_way_unit #(.TagW(TagW), .WayW(WayW)) u_way (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .first_i    (rway_q == '0),
    .step_i     (rv_q),
    .way_i      (rway_q),
    .valid_i    (m_valid),
    .tag_i      (m_tag),
    .age_i      (m_age),
    .look_tag_i (tag),
    .hit_o      (u_hit),
    .hit_way_o  (hit_way),
    .inv_o      (u_inv),
    .inv_way_o  (inv_way),
    .old_way_o  (old_way)
  );

  // Write side for the update pass: recompute each way from its staged copy.
  logic [EntW-1:0] upd_ent;
  logic            k_v, k_d;
  logic [TagW-1:0] k_t;
  logic [AgeW-1:0] k_a;
  logic            is_rw, mark;
  assign {k_v, k_d, k_t, k_a} = way_keep_q[cnt_q];
  assign is_rw = (op_q == OpRead) || (op_q == OpWrite);
  assign mark  = (op_q == OpWrite) && !wt_q;

  always_comb begin
    upd_ent = way_keep_q[cnt_q];
    if (!is_rw) begin
      upd_ent = {1'b0, 1'b0, k_t, k_a};
    end else if (cnt_q == sel_q) begin
      if (hit_q) begin
        upd_ent = {1'b1, k_d | mark, k_t, {AgeW{1'b0}}};
      end else begin
        upd_ent = {1'b1, mark, tag, {AgeW{1'b0}}};
      end
    end else if (k_v && k_a != AgeMax) begin
      upd_ent = {k_v, k_d, k_t, k_a + AgeW'(1)};
    end
  end

  // Read one way ahead: way 0 of the new set at accept, then the next way.
  always_comb begin
    we    = 1'b0;
    waddr = line_of(set_idx, cnt_q);
    wdata = upd_ent;
    if (st_q == StIdle) begin
      raddr = line_of(in_set, '0);
    end else begin
      raddr = line_of(set_idx, rway_q + WayW'(1));
    end
    if (st_q == StWipe) begin
      we    = 1'b1;
      waddr = wipe_q;
      wdata = '0;
    end else if (st_q == StUpd) begin
      we = is_rw || sel_ok_q;
    end
  end

  function automatic logic [31:0] sat(logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  logic [31:0] ev_addr;
  always_comb begin
    logic [63:0] t;
    t = ((64'(way_keep_q[old_way][AgeW +: TagW]) * 64'(NUM_SETS)) + 64'(set_idx))
        * 64'(BLOCK_BYTES);
    ev_addr = t[31:0] | (addr_q & 32'(BLOCK_BYTES - 1));
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StWipe: if (wipe_q == LastLine) st_d = StIdle;
      StIdle: if (start_i) st_d = (op_i == OpClear) ? StWipe : StRead;
      StRead: if (rv_q && rway_q == LastWay) st_d = StDec;
      StDec:  st_d = StUpd;
      StUpd:  if (!is_rw || cnt_q == LastWay) st_d = StDone;
      StDone: st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StWipe;
      wipe_q <= '0;
      cnt_q <= '0;
      rv_q <= 1'b0;
      rway_q <= '0;
      op_q <= OpRead;
      addr_q <= '0;
      wt_q <= 1'b0;
      rd_q <= '0;
      wr_q <= '0;
      ht_q <= '0;
      ms_q <= '0;
      done_q <= 1'b0;
      hit_q <= 1'b0;
      wb_q <= 1'b0;
      found_q <= 1'b0;
      ev_q <= '0;
      sel_q <= '0;
      sel_ok_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= 1'b0;
      rv_q   <= 1'b0;
      if (cfg_we_i) wt_q <= write_through_i;
      unique case (st_q)
        StWipe: begin
          wipe_q <= wipe_q + LineW'(1);
          if (wipe_q == LastLine && op_q == OpClear && sel_ok_q) begin
            done_q <= 1'b1;
          end
        end
        StIdle: begin
          hit_q <= 1'b0;
          wb_q <= 1'b0;
          found_q <= 1'b0;
          ev_q <= '0;
          cnt_q <= '0;
          if (start_i) begin
            op_q   <= op_i;
            addr_q <= address_i;
            if (op_i == OpClear) begin
              wipe_q <= '0;
              rd_q <= '0;
              wr_q <= '0;
              ht_q <= '0;
              ms_q <= '0;
              sel_ok_q <= 1'b1;
            end else begin
              sel_ok_q <= 1'b0;
              rv_q   <= 1'b1;
              rway_q <= '0;
              if (op_i == OpWrite) wr_q <= sat(wr_q);
              if (op_i == OpRead)  rd_q <= sat(rd_q);
            end
          end
        end
        StRead: begin
          way_keep_q[rway_q] <= rdata;
          if (rway_q != LastWay) begin
            rv_q   <= 1'b1;
            rway_q <= rway_q + WayW'(1);
            cnt_q  <= cnt_q + WayW'(1);
          end
        end
        StDec: begin
          if (is_rw) begin
            cnt_q <= '0;
            hit_q <= u_hit;
            if (u_hit) begin
              ht_q  <= sat(ht_q);
              sel_q <= hit_way;
            end else begin
              ms_q  <= sat(ms_q);
              sel_q <= u_inv ? inv_way : old_way;
              if (!u_inv && way_keep_q[old_way][EntW-2] && !wt_q) begin
                wb_q <= 1'b1;
                ev_q <= ev_addr;
              end
            end
          end else begin
            sel_q    <= hit_way;
            found_q  <= u_hit;
            sel_ok_q <= u_hit;
            cnt_q    <= hit_way;
          end
        end
        StUpd: begin
          if (is_rw) cnt_q <= cnt_q + WayW'(1);
        end
        StDone: done_q <= 1'b1;
        default: ;
      endcase
    end
  end

  assign busy_o            = (st_q != StIdle);
  assign done_o            = done_q;
  assign hit_o             = hit_q;
  assign writeback_o       = wb_q;
  assign evicted_address_o = ev_q;
  assign line_found_o      = found_q;
  assign read_count_o      = rd_q;
  assign write_count_o     = wr_q;
  assign hit_count_o       = ht_q;
  assign miss_count_o      = ms_q;

  // Invalidate with no match must not write memory.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StUpd && !is_rw && !sel_ok_q) |-> !we)
    else $error("invalidate wrote without a match");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !(hit_q && found_q))
    else $error("hit and line_found together");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !wb_q) |-> (ev_q == '0))
    else $error("evicted address without writeback");
endmodule
`default_nettype wire

FILE: verif/set_assoc_cache_tag_controller_tb.sv
module set_assoc_cache_tag_controller_tb;
  import sact_pkg::*;

  localparam int unsigned SETS  = NumSetsDefault;
  localparam int unsigned WAYS  = NumWaysDefault;
  localparam int unsigned LINES = SETS * WAYS;
  localparam int unsigned OFF_W = $clog2(BlockBytesDefault);
  localparam int unsigned SET_W = $clog2(SETS);
  localparam int unsigned TAG_W = 32 - OFF_W - SET_W;
  localparam int unsigned N_ITEMS = 1900;
  localparam longint CYCLE_LIMIT = 3_000_000;

  typedef struct packed {
    logic        hit;
    logic        writeback;
    logic [31:0] evicted;
    logic        found;
    logic [31:0] reads;
    logic [31:0] writes;
    logic [31:0] hits;
    logic [31:0] misses;
  } outcome_t;

  // Tag-store shadow: predicts every outcome and matches it against the block.
  class tag_store_shadow;
    bit              vld[LINES];
    bit              drt[LINES];
    bit [TAG_W-1:0]  tg[LINES];
    bit [AgeW-1:0]   age[LINES];
    bit [31:0]       reads, writes, hits, misses;
    bit              wt;
    outcome_t        pending[$];
    int              n_errors;
    int              n_checked;
    int              n_hits, n_wbacks, n_found;

    function void wipe();
      for (int i = 0; i < LINES; i++) begin
        vld[i] = 0; drt[i] = 0; tg[i] = '0; age[i] = '0;
      end
      reads = 0; writes = 0; hits = 0; misses = 0;
    endfunction

    function bit [31:0] bump(bit [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 1;
    endfunction

    // Age every other valid way, zero the touched one.
    function void refresh_ages(int base, int way);
      for (int w = 0; w < WAYS; w++)
        if (w != way && vld[base+w] && age[base+w] != AgeMax) age[base+w]++;
      age[base+way] = '0;
    endfunction

    function void note_command(logic [1:0] op, logic [31:0] addr);
      outcome_t        o;
      bit [OFF_W-1:0]  off;
      bit [SET_W-1:0]  set;
      bit [TAG_W-1:0]  tag;
      int              base, v, best, top;
      bit              mark;
      o = '0;
      off = addr[OFF_W-1:0];
      set = addr[OFF_W +: SET_W];
      tag = addr[31 -: TAG_W];
      base = int'(set) * WAYS;
      if (op == OpClear) begin
        wipe();
      end else if (op == OpInval) begin
        for (int w = 0; w < WAYS; w++)
          if (vld[base+w] && tg[base+w] == tag) begin
            vld[base+w] = 0; drt[base+w] = 0; o.found = 1;
            break;
          end
      end else begin
        mark = (op == OpWrite) && !wt;
        if (op == OpWrite) writes = bump(writes);
        else reads = bump(reads);
        for (int w = 0; w < WAYS; w++)
          if (vld[base+w] && tg[base+w] == tag) begin
            o.hit = 1;
            hits = bump(hits);
            if (mark) drt[base+w] = 1;
            refresh_ages(base, w);
            break;
          end
        if (!o.hit) begin
          misses = bump(misses);
          // Prefer the lowest invalid way, else the oldest (lowest on ties).
          v = -1; best = 0; top = -1;
          for (int w = 0; w < WAYS; w++) begin
            if (!vld[base+w]) begin v = w; break; end
            if (int'(age[base+w]) > top) begin top = int'(age[base+w]); best = w; end
          end
          if (v < 0) v = best;
          if (vld[base+v] && drt[base+v] && !wt) begin
            o.writeback = 1;
            o.evicted = {tg[base+v], set, off};
          end
          vld[base+v] = 1; drt[base+v] = mark; tg[base+v] = tag; age[base+v] = '0;
          refresh_ages(base, v);
        end
      end
      o.reads = reads; o.writes = writes; o.hits = hits; o.misses = misses;
      pending.push_back(o);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      n_errors++;
      $display("mismatch #%0d on result %0d: %s got %h expected %h",
               n_errors, n_checked, what, got, want);
    endtask

    task check_result(outcome_t got);
      outcome_t want;
      n_checked++;
      if (pending.size() == 0) begin
        report("result with nothing outstanding", 32'd1, 32'd0);
        return;
      end
      want = pending.pop_front();
      if (got.hit       !== want.hit)       report("hit", got.hit, want.hit);
      if (got.writeback !== want.writeback) report("writeback", got.writeback, want.writeback);
      if (got.evicted   !== want.evicted)   report("evicted_address", got.evicted, want.evicted);
      if (got.found     !== want.found)     report("line_found", got.found, want.found);
      if (got.reads     !== want.reads)     report("read_count", got.reads, want.reads);
      if (got.writes    !== want.writes)    report("write_count", got.writes, want.writes);
      if (got.hits      !== want.hits)      report("hit_count", got.hits, want.hits);
      if (got.misses    !== want.misses)    report("miss_count", got.misses, want.misses);
      n_hits   += want.hit;
      n_wbacks += want.writeback;
      n_found  += want.found;
    endtask
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start_i = 0;
  logic [1:0]  op_i = OpRead;
  logic [31:0] address_i = '0;
  logic        cfg_we_i = 0;
  logic        write_through_i = 0;
  logic        busy_o, done_o, hit_o, writeback_o, line_found_o;
  logic [31:0] evicted_address_o, read_count_o, write_count_o, hit_count_o, miss_count_o;

  tag_store_shadow shadow;
  longint cycles = 0;
  int     n_sent = 0;
  int     n_clears = 0;

  set_assoc_cache_tag_controller dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .op_i, .address_i, .cfg_we_i,
    .write_through_i, .done_o, .hit_o, .writeback_o, .evicted_address_o,
    .line_found_o, .read_count_o, .write_count_o, .hit_count_o, .miss_count_o
  );

  always #5 clk_i = ~clk_i;

  // Hard stop if the block hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, shadow.pending.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Capture each result transaction; the block cannot be stalled.
  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      shadow.check_result('{hit_o, writeback_o, evicted_address_o, line_found_o,
                             read_count_o, write_count_o, hit_count_o, miss_count_o});
  end

  // Idle for a random number of cycles: mostly none or short, now and then long.
  task automatic idle_gap();
    int n;
    n = $urandom_range(0, 99);
    if (n < 45) n = 0;
    else if (n < 92) n = $urandom_range(1, 4);
    else n = $urandom_range(10, 60);
    if (n > 0) begin
      start_i <= 0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Present one command and hold it until the block takes it.
  // Leave start high afterwards so back-to-back transactions need no toggle.
  task automatic issue(logic [1:0] op, logic [31:0] addr, bit gaps = 1);
    if (gaps) idle_gap();
    start_i   <= 1;
    op_i      <= op;
    address_i <= addr;
    do @(posedge clk_i); while (busy_o);
    shadow.note_command(op, addr);
    n_sent++;
    if (op == OpClear) n_clears++;
  endtask

  // Drain every outstanding result, let the block settle, then flip the mode.
  task automatic set_write_through(bit v);
    start_i <= 0;
    @(posedge clk_i);
    while (shadow.pending.size() != 0) @(posedge clk_i);
    repeat (2 * WAYS + 8) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    cfg_we_i        <= 1;
    write_through_i <= v;
    @(posedge clk_i);
    shadow.wt = v;
    cfg_we_i <= 0;
  endtask

  function automatic logic [31:0] make_addr(logic [TAG_W-1:0] tag, logic [SET_W-1:0] set,
                                            logic [OFF_W-1:0] off);
    return {tag, set, off};
  endfunction

  // Random command drawn from a small pool of sets and tags so that sets
  // fill up, hit, and evict; a slice uses fully random addresses.
  task automatic random_command();
    logic [1:0]       op;
    logic [TAG_W-1:0] tag;
    logic [SET_W-1:0] set;
    logic [31:0]      addr;
    int               r;
    r = $urandom_range(0, 99);
    op = (r < 42) ? OpRead : (r < 85) ? OpWrite : OpInval;
    set = (SET_W)'($urandom_range(0, 3) * 1237 + 5);
    tag = (TAG_W)'($urandom_range(0, WAYS + 3) * 411);
    addr = make_addr(tag, set, (OFF_W)'($urandom));
    if ($urandom_range(0, 9) == 0) addr = $urandom;
    issue(op, addr);
  endtask

  initial begin
    logic [SET_W-1:0] s;
    shadow = new();
    shadow.wipe();
    shadow.wt = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;

    // Directed: address extremes, hit after fill, dirty eviction, invalidate
    // hit and miss, write-through suppressing write-back of an old dirty line.
    set_write_through(0);
    issue(OpRead,  32'h0000_0000, 0);
    issue(OpWrite, 32'hFFFF_FFFF, 0);
    issue(OpRead,  32'hFFFF_FFC0, 0);
    s = SET_W'(77);
    for (int t = 1; t <= WAYS + 1; t++)
      issue(OpWrite, make_addr(TAG_W'(t), s, OFF_W'(t * 3)), 0);
    issue(OpRead,  make_addr(TAG_W'(2), s, '1), 0);
    issue(OpInval, make_addr(TAG_W'(3), s, '0), 0);
    issue(OpInval, make_addr(TAG_W'(3), s, '0), 0);
    issue(OpRead,  make_addr(TAG_W'(9), s, '0), 0);
    issue(OpClear, 32'h1234_5678, 0);
    issue(OpWrite, make_addr(TAG_W'(5), s, '0), 0);
    set_write_through(1);
    for (int t = 6; t <= WAYS + 6; t++)
      issue(OpWrite, make_addr(TAG_W'(t), s, OFF_W'(t)), 0);
    issue(OpInval, 32'hFFFF_FFFF, 0);

    // Random: three phases (write-back, write-through, write-back), one clear mid-run.
    set_write_through(0);
    for (int i = 0; i < N_ITEMS / 2; i++) random_command();
    issue(OpClear, $urandom);
    set_write_through(1);
    for (int i = 0; i < N_ITEMS / 4; i++) random_command();
    set_write_through(0);
    for (int i = 0; i < N_ITEMS / 4; i++) random_command();

    start_i <= 0;
    while (shadow.pending.size() != 0) @(posedge clk_i);
    repeat (4 * WAYS + 20) @(posedge clk_i);

    $display("sent %0d commands (%0d clears), checked %0d results", n_sent, n_clears,
             shadow.n_checked);
    $display("saw %0d hits, %0d write-backs, %0d invalidate matches",
             shadow.n_hits, shadow.n_wbacks, shadow.n_found);
    if (shadow.n_errors == 0 && shadow.pending.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
